### rtl/sseq_pkg.sv
// Shared types, constants and codes for the slot sequencer.
package sseq_pkg;

  localparam int unsigned MAX_CHANNELS     = 512;
  localparam int unsigned PACKET_MAX_BYTES = 1024;
  localparam int unsigned CH_AW            = $clog2(MAX_CHANNELS);
  localparam int unsigned PKT_W            = $clog2(PACKET_MAX_BYTES) + 1;

  localparam logic [PKT_W-1:0] PKT_START_CODE_POS = PKT_W'(125);
  localparam logic [PKT_W-1:0] PKT_FIRST_CHAN_POS = PKT_W'(126);
  localparam logic [PKT_W-1:0] PKT_LIMIT          = PKT_W'(PACKET_MAX_BYTES);
  localparam logic [9:0]       CMD_MAX_VALUE      = 10'd255;
  localparam logic [9:0]       CMD_PAUSE_VALUE    = 10'd2;

  // Request actions
  localparam logic [1:0] ACT_COMMAND = 2'd0;
  localparam logic [1:0] ACT_PACKET  = 2'd1;
  localparam logic [1:0] ACT_SLOT    = 2'd2;

  // Slot kinds
  localparam logic [2:0] KIND_IDLE       = 3'd0;
  localparam logic [2:0] KIND_REAL_BREAK = 3'd1;
  localparam logic [2:0] KIND_SIM_BREAK  = 3'd2;
  localparam logic [2:0] KIND_START      = 3'd3;
  localparam logic [2:0] KIND_CHANNEL    = 3'd4;

  // Register indexes on the APB port
  localparam logic [2:0] REG_SLOT_COUNT  = 3'd0;
  localparam logic [2:0] REG_MAB_US      = 3'd1;
  localparam logic [2:0] REG_SLOT_GAP_US = 3'd2;
  localparam logic [2:0] REG_FRAME_GAP   = 3'd3;
  localparam logic [2:0] REG_REAL_BREAK  = 3'd4;

  typedef struct packed {
    logic [1:0] action;
    logic [9:0] channel_number;
    logic [9:0] command_value;
    logic [7:0] packet_byte;
    logic       packet_last;
  } sseq_req_t;

  typedef struct packed {
    logic [2:0]  slot_kind;
    logic [7:0]  slot_byte;
    logic [15:0] gap_us;
    logic        frame_last;
  } sseq_result_t;

endpackage

### rtl/sseq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sseq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dmx512_slot_sequencer_core.sv
// Top level of the slot sequencer: channel store, packet intake, frame sequencing.
//
//   port group          | direction | handshake
//   --------------------+-----------+-------------------------------------------
//   req_i               | in        | taken when start is high and busy is low
//   result_o            | out       | valid for one cycle while result_valid_o
//   psel..pready/prdata | both      | APB register port, zero wait states
//
// A request is taken when start is high and busy is low; a new one can follow
// in the next cycle. A slot request answers in the cycle after acceptance; channel
// bytes come from the registered read port of the channel store RAM. After reset busy
// stays high while all 512 store entries are swept to zero; register access works
// throughout. The receiver cannot stall results, so no result is held back.
module dmx512_slot_sequencer_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  sseq_pkg::sseq_req_t   req_i,
  output logic                  result_valid_o,
  output sseq_pkg::sseq_result_t result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import sseq_pkg::*;

  // Configuration registers
  logic [9:0]  slot_count_q;
  logic [15:0] mab_us_q;
  logic [15:0] slot_gap_us_q;
  logic [15:0] frame_gap_us_q;
  logic        real_break_q;

  // Sequencer state
  logic [7:0]       start_code_q, start_code_d;
  logic             paused_q, paused_d;
  logic [PKT_W-1:0] pkt_pos_q, pkt_pos_d;
  logic [9:0]       slot_pos_q, slot_pos_d;

  // Store clearing sweep after reset
  logic             clr_active_q;
  logic [CH_AW-1:0] clr_idx_q;

  // Result stage
  logic        res_valid_q;
  logic [2:0]  res_kind_q;
  logic [7:0]  res_byte_q;
  logic [15:0] res_gap_q;
  logic        res_last_q;
  logic        res_use_ram_q;

  // RAM ports
  logic             ram_we;
  logic [CH_AW-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [CH_AW-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  logic       accept;
  logic       cfg_write;
  logic [2:0] cfg_idx;
  logic [9:0] count;

  // Combinational results of one request
  logic             upd_we;
  logic [CH_AW-1:0] upd_waddr;
  logic [7:0]       upd_wdata;
  logic             slot_hit;
  logic [2:0]       kind_d;
  logic [7:0]       byte_d;
  logic [15:0]      gap_d;
  logic             last_d;
  logic             use_ram_d;
  logic [10:0]      pos_eff;
  logic [10:0]      pkt_chan;

  assign busy      = clr_active_q;
  assign accept    = start && !busy;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = paddr[4:2];

  // Saturate the slot count at the store depth
  assign count = (slot_count_q > 10'(MAX_CHANNELS)) ? 10'(MAX_CHANNELS) : slot_count_q;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q   <= 10'd20;
      mab_us_q       <= 16'd12;
      slot_gap_us_q  <= 16'd0;
      frame_gap_us_q <= 16'd0;
      real_break_q   <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_SLOT_COUNT:  slot_count_q   <= pwdata[9:0];
        REG_MAB_US:      mab_us_q       <= pwdata[15:0];
        REG_SLOT_GAP_US: slot_gap_us_q  <= pwdata[15:0];
        REG_FRAME_GAP:   frame_gap_us_q <= pwdata[15:0];
        REG_REAL_BREAK:  real_break_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_SLOT_COUNT:  prdata = {22'd0, slot_count_q};
      REG_MAB_US:      prdata = {16'd0, mab_us_q};
      REG_SLOT_GAP_US: prdata = {16'd0, slot_gap_us_q};
      REG_FRAME_GAP:   prdata = {16'd0, frame_gap_us_q};
      REG_REAL_BREAK:  prdata = {31'd0, real_break_q};
      default:         prdata = '0;
    endcase
  end

  // Decode one request: store writes, state update, slot selection
  always_comb begin
    start_code_d = start_code_q;
    paused_d     = paused_q;
    pkt_pos_d    = pkt_pos_q;
    slot_pos_d   = slot_pos_q;
    upd_we       = 1'b0;
    upd_waddr    = '0;
    upd_wdata    = '0;
    slot_hit     = 1'b0;
    kind_d       = KIND_IDLE;
    byte_d       = '0;
    gap_d        = '0;
    last_d       = 1'b0;
    use_ram_d    = 1'b0;
    pkt_chan     = 11'(pkt_pos_q - PKT_FIRST_CHAN_POS);

    // Wrap the frame when the count was lowered under the current slot
    pos_eff = (11'(slot_pos_q) >= 11'(count) + 11'd2) ? 11'd0 : 11'(slot_pos_q);

    if (accept) begin
      case (req_i.action)
        ACT_COMMAND: begin
          // Any command clears pause; channel 0 value 2 sets it again
          paused_d = (req_i.channel_number == 10'd0) &&
                     (req_i.command_value == CMD_PAUSE_VALUE);
          if (req_i.channel_number != 10'd0 && req_i.channel_number <= count &&
              req_i.command_value <= CMD_MAX_VALUE) begin
            upd_we    = 1'b1;
            upd_waddr = CH_AW'(req_i.channel_number - 10'd1);
            upd_wdata = req_i.command_value[7:0];
          end
        end
        ACT_PACKET: begin
          if (pkt_pos_q < PKT_LIMIT) begin
            if (pkt_pos_q == PKT_START_CODE_POS) begin
              start_code_d = req_i.packet_byte;
            end else if (pkt_pos_q >= PKT_FIRST_CHAN_POS && pkt_chan < 11'(count)) begin
              upd_we    = 1'b1;
              upd_waddr = pkt_chan[CH_AW-1:0];
              upd_wdata = req_i.packet_byte;
            end
            pkt_pos_d = pkt_pos_q + PKT_W'(1);
          end
          if (req_i.packet_last) begin
            pkt_pos_d = '0;
          end
        end
        ACT_SLOT: begin
          slot_hit = 1'b1;
          if (pos_eff == 11'd0) begin
            slot_pos_d = '0;
            if (!paused_q) begin
              kind_d     = real_break_q ? KIND_REAL_BREAK : KIND_SIM_BREAK;
              gap_d      = frame_gap_us_q;
              slot_pos_d = 10'd1;
            end
          end else if (pos_eff == 11'd1) begin
            kind_d = KIND_START;
            byte_d = start_code_q;
            gap_d  = mab_us_q;
            if (count == 10'd0) begin
              last_d     = 1'b1;
              slot_pos_d = '0;
            end else begin
              slot_pos_d = 10'd2;
            end
          end else begin
            kind_d    = KIND_CHANNEL;
            gap_d     = slot_gap_us_q;
            use_ram_d = 1'b1;
            // Last channel when slot index plus one reaches the count
            if (pos_eff - 11'd1 >= 11'(count)) begin
              last_d     = 1'b1;
              slot_pos_d = '0;
            end else begin
              slot_pos_d = 10'(pos_eff + 11'd1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Sweep zeros into the store after reset, then hand the port to requests
  assign ram_we    = clr_active_q || upd_we;
  assign ram_waddr = clr_active_q ? clr_idx_q : upd_waddr;
  assign ram_wdata = clr_active_q ? 8'd0 : upd_wdata;
  assign ram_raddr = CH_AW'(pos_eff - 11'd2);

  sseq_ram #(
    .WIDTH (8),
    .DEPTH (MAX_CHANNELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_idx_q    <= '0;
      start_code_q <= '0;
      paused_q     <= 1'b0;
      pkt_pos_q    <= '0;
      slot_pos_q   <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      if (clr_active_q) begin
        clr_idx_q <= clr_idx_q + CH_AW'(1);
        if (clr_idx_q == CH_AW'(MAX_CHANNELS - 1)) begin
          clr_active_q <= 1'b0;
        end
      end
      start_code_q <= start_code_d;
      paused_q     <= paused_d;
      pkt_pos_q    <= pkt_pos_d;
      slot_pos_q   <= slot_pos_d;
      res_valid_q  <= slot_hit;
    end
  end

  // Result payload: hold the decoded slot alongside the RAM read
  always_ff @(posedge clk_i) begin
    if (slot_hit) begin
      res_kind_q    <= kind_d;
      res_byte_q    <= byte_d;
      res_gap_q     <= gap_d;
      res_last_q    <= last_d;
      res_use_ram_q <= use_ram_d;
    end
  end

  assign result_valid_o       = res_valid_q;
  assign result_o.slot_kind   = res_kind_q;
  assign result_o.slot_byte   = res_use_ram_q ? ram_rdata : res_byte_q;
  assign result_o.gap_us      = res_gap_q;
  assign result_o.frame_last  = res_last_q;

  // A slot request answers in the next cycle
  a_slot_answers : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.action == ACT_SLOT) |=> result_valid_o)
    else $error("slot request without result");

  // No result appears during the store sweep
  a_no_result_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy)) |-> !result_valid_o)
    else $error("result during store clearing");

  // Slot position never runs past the last channel slot
  a_slot_pos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_pos_q <= 10'(MAX_CHANNELS + 1))
    else $error("slot position out of range");

  // Idle slots carry no byte, no gap and no frame end
  a_idle_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.slot_kind == KIND_IDLE) |->
      (result_o.slot_byte == 8'd0 && result_o.gap_us == 16'd0 && !result_o.frame_last))
    else $error("idle slot with payload");

endmodule

### tb/sv/tb_dmx512_slot_sequencer_core.sv
// Self-checking testbench for the slot sequencer core: random requests, APB setup, slot checks.
`timescale 1ns / 100ps

module tb_dmx512_slot_sequencer_core;
  import sseq_pkg::*;

  // Action code with no function in the block; it must be dropped silently.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    sseq_req_t   req;
    int unsigned gap;   // idle cycles after this request is taken
  } pending_t;

  logic         clk_i   = 1'b0;
  logic         rst_ni  = 1'b0;
  logic         start   = 1'b0;
  logic         busy;
  sseq_req_t    req_i   = '0;
  logic         result_valid_o;
  sseq_result_t result_o;
  logic         psel    = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite  = 1'b0;
  logic [4:0]   paddr   = '0;
  logic [31:0]  pwdata  = '0;
  logic [31:0]  prdata;
  logic         pready;

  dmx512_slot_sequencer_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the register file, updated at each APB write edge.
  logic [9:0]  cfg_slot_count   = 10'd20;
  logic [15:0] cfg_mab_us       = 16'd12;
  logic [15:0] cfg_slot_gap_us  = 16'd0;
  logic [15:0] cfg_frame_gap_us = 16'd0;
  logic        cfg_real_break   = 1'b0;

  // Shadow copy of the block state: channel store, start code, pause, positions.
  logic [7:0]  chan_mem [MAX_CHANNELS] = '{default: 8'h00};
  logic [7:0]  start_code_q = 8'h00;
  logic        paused_q     = 1'b0;
  int unsigned pkt_pos      = 0;
  int unsigned frame_pos    = 0;   // 0 break, 1 start code, 2.. channel slots

  pending_t     pending[$];        // requests waiting for the driver
  sseq_result_t slot_due[$];       // predicted slots not yet seen on the output
  pending_t     next_item;
  sseq_result_t slot_want;
  int unsigned  gap_left = 0;
  int unsigned  err_cnt  = 0;
  int unsigned  queued   = 0;
  bit           gap_mode = 1'b0;

  function automatic int unsigned active_slots();
    return (cfg_slot_count > MAX_CHANNELS) ? MAX_CHANNELS : cfg_slot_count;
  endfunction

  function automatic void flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t: %s", $time, msg);
  endfunction

  // Advance the shadow state by one taken request; queue the slot it yields.
  task automatic apply_request(input sseq_req_t r);
    int unsigned  n;
    int unsigned  idx;
    sseq_result_t res;
    n   = active_slots();
    res = '0;
    case (r.action)
      ACT_COMMAND: begin
        // any command clears the pause; only channel 0 with the pause value sets it
        paused_q = (r.channel_number == 0) && (r.command_value == CMD_PAUSE_VALUE);
        if (r.channel_number != 0 && r.channel_number <= n &&
            r.command_value <= CMD_MAX_VALUE) begin
          chan_mem[r.channel_number - 1] = r.command_value[7:0];
        end
      end
      ACT_PACKET: begin
        if (pkt_pos < PACKET_MAX_BYTES) begin
          if (pkt_pos == PKT_START_CODE_POS) begin
            start_code_q = r.packet_byte;
          end else if (pkt_pos >= PKT_FIRST_CHAN_POS && pkt_pos - PKT_FIRST_CHAN_POS < n) begin
            chan_mem[pkt_pos - PKT_FIRST_CHAN_POS] = r.packet_byte;
          end
          pkt_pos++;
        end
        if (r.packet_last) pkt_pos = 0;
      end
      ACT_SLOT: begin
        // a frame cut short by a lower slot count restarts at the break
        if (frame_pos >= n + 2) frame_pos = 0;
        if (frame_pos == 0) begin
          if (!paused_q) begin
            res.slot_kind = cfg_real_break ? KIND_REAL_BREAK : KIND_SIM_BREAK;
            res.gap_us    = cfg_frame_gap_us;
            frame_pos     = 1;
          end
        end else if (frame_pos == 1) begin
          res.slot_kind = KIND_START;
          res.slot_byte = start_code_q;
          res.gap_us    = cfg_mab_us;
          if (n == 0) begin
            res.frame_last = 1'b1;
            frame_pos      = 0;
          end else begin
            frame_pos = 2;
          end
        end else begin
          idx           = frame_pos - 2;
          res.slot_kind = KIND_CHANNEL;
          res.slot_byte = chan_mem[idx];
          res.gap_us    = cfg_slot_gap_us;
          if (idx + 1 >= n) begin
            res.frame_last = 1'b1;
            frame_pos      = 0;
          end else begin
            frame_pos++;
          end
        end
        slot_due.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Driver: hold the request until taken, then idle for its gap and fetch the next.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (gap_left != 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending.size() != 0) begin
        next_item = pending.pop_front();
        req_i    <= next_item.req;
        start    <= 1'b1;
        gap_left <= next_item.gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predict on every taken request, then check any slot on the output.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) apply_request(req_i);
      if (result_valid_o) begin
        if (slot_due.size() == 0) begin
          flag_error($sformatf("unexpected slot: kind %0d byte %02h gap %0d last %0b",
                               result_o.slot_kind, result_o.slot_byte, result_o.gap_us,
                               result_o.frame_last));
        end else begin
          slot_want = slot_due.pop_front();
          if (result_o.slot_kind !== slot_want.slot_kind ||
              result_o.slot_byte !== slot_want.slot_byte ||
              result_o.gap_us !== slot_want.gap_us ||
              result_o.frame_last !== slot_want.frame_last) begin
            flag_error($sformatf({"slot mismatch: expected kind %0d byte %02h gap %0d last %0b,",
                                  " got kind %0d byte %02h gap %0d last %0b"},
                                 slot_want.slot_kind, slot_want.slot_byte, slot_want.gap_us,
                                 slot_want.frame_last, result_o.slot_kind, result_o.slot_byte,
                                 result_o.gap_us, result_o.frame_last));
          end
        end
      end
    end
  end

  // Mostly short gaps, a few long ones; none at all when the phase runs back to back.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gap_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sseq_req_t rand_fields(input logic [1:0] act);
    sseq_req_t r;
    r.action         = act;
    r.channel_number = 10'($urandom);
    r.command_value  = 10'($urandom);
    r.packet_byte    = 8'($urandom);
    r.packet_last    = 1'($urandom);
    return r;
  endfunction

  task automatic send(input sseq_req_t r);
    pending_t p;
    p.req = r;
    p.gap = pick_gap();
    pending.push_back(p);
    queued++;
  endtask

  task automatic send_cmd(input logic [9:0] ch, input logic [9:0] val);
    sseq_req_t r;
    r                = rand_fields(ACT_COMMAND);
    r.channel_number = ch;
    r.command_value  = val;
    send(r);
  endtask

  // Mostly in-range writes; some control commands, channels past the count, wide values.
  task automatic send_rand_cmd(input int unsigned n_act);
    int unsigned sel;
    logic [9:0]  ch;
    sel = $urandom_range(0, 9);
    if (sel == 0)      ch = 10'd0;
    else if (sel == 1) ch = 10'($urandom_range(n_act + 1, 1023));
    else               ch = 10'($urandom_range(1, (n_act == 0) ? 1 : n_act));
    if ($urandom_range(0, 4) == 0) send_cmd(ch, 10'($urandom_range(256, 1023)));
    else                           send_cmd(ch, 10'($urandom_range(0, 255)));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    sseq_req_t r;
    r             = rand_fields(ACT_PACKET);
    r.packet_byte = b;
    r.packet_last = last;
    send(r);
  endtask

  task automatic send_packet(input int unsigned len, input bit close);
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom), close && (i == len - 1));
  endtask

  task automatic send_slots(input int unsigned n);
    repeat (n) send(rand_fields(ACT_SLOT));
  endtask

  // Wait for the sender to empty, let the last slots arrive, drop any that never came.
  task automatic drain_requests();
    int unsigned waited;
    waited = 0;
    while (pending.size() != 0 || start) @(negedge clk_i);
    while (slot_due.size() != 0 && waited < 32) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (4) @(negedge clk_i);
    if (slot_due.size() != 0) begin
      flag_error($sformatf("%0d predicted slots never appeared", slot_due.size()));
      slot_due.delete();
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SLOT_COUNT:  cfg_slot_count   = val[9:0];
      REG_MAB_US:      cfg_mab_us       = val[15:0];
      REG_SLOT_GAP_US: cfg_slot_gap_us  = val[15:0];
      REG_FRAME_GAP:   cfg_frame_gap_us = val[15:0];
      REG_REAL_BREAK:  cfg_real_break   = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned count, input int unsigned mab,
                            input int unsigned slot_gap, input int unsigned frame_gap,
                            input int unsigned real_brk);
    write_reg(REG_SLOT_COUNT, count);
    write_reg(REG_MAB_US, mab);
    write_reg(REG_SLOT_GAP_US, slot_gap);
    write_reg(REG_FRAME_GAP, frame_gap);
    write_reg(REG_REAL_BREAK, real_brk);
  endtask

  // One random phase: frame runs, commands, pause sequences, packets and noise.
  task automatic run_phase(input int unsigned quota);
    int unsigned stop_at;
    int unsigned n_act;
    int unsigned sel;
    stop_at  = queued + quota;
    n_act    = active_slots();
    gap_mode = ($urandom_range(0, 3) != 0);
    while (queued < stop_at) begin
      sel = $urandom_range(0, 19);
      if (sel < 8) begin
        send_slots($urandom_range(1, (n_act + 3 > 24) ? 24 : n_act + 3));
      end else if (sel < 12) begin
        repeat ($urandom_range(1, 4)) send_rand_cmd(n_act);
      end else if (sel < 14) begin
        // pause, keep asking for slots, then release with an ordinary command
        send_cmd(10'd0, CMD_PAUSE_VALUE);
        send_slots($urandom_range(1, 3));
        if ($urandom_range(0, 1)) send_rand_cmd(n_act);
      end else if (sel < 17) begin
        if ($urandom_range(0, 9) < 7) send_packet(126 + $urandom_range(0, 14), 1'b1);
        else                          send_packet($urandom_range(1, 130), $urandom_range(0, 1));
      end else begin
        repeat ($urandom_range(1, 3)) send(rand_fields(2'($urandom_range(0, 3))));
      end
    end
    drain_requests();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests under the reset settings (20 slots, 12 us mark after break).
    send_cmd(10'd1, 10'd255);
    send_cmd(10'd20, 10'd128);
    send_cmd(10'd21, 10'd77);       // past the slot count: drop
    send_cmd(10'd1023, 10'd1023);
    send_cmd(10'd2, 10'd256);       // value wider than a byte: drop
    send_cmd(10'd3, 10'd0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b1);
    send(rand_fields(ACT_UNUSED));
    send_cmd(10'd0, CMD_PAUSE_VALUE);
    send_slots(1);                  // paused at frame start: idle
    send_cmd(10'd0, 10'd0);
    send_slots(2);                  // break, start code
    send_cmd(10'd0, CMD_PAUSE_VALUE);
    send_slots(2);                  // frame already begun keeps running
    send_cmd(10'd0, 10'd1023);
    send_slots(1);
    drain_requests();

    set_config(3, 0, 16'hFFFF, 1, 1);
    run_phase(10);
    set_config(0, 16'hFFFF, 7, 16'hFFFF, 0);   // frame of break and start code only
    run_phase(10);

    // Count past the store size saturates; fill the store from one packet long enough
    // to hit the position limit, then walk more than a whole frame.
    set_config(1023, 100, 0, 88, 1);
    gap_mode = 1'b1;
    send_byte(8'($urandom), 1'b1);
    send_packet(PACKET_MAX_BYTES + 6, 1'b1);
    send_cmd(10'd0, 10'd0);
    send_slots(MAX_CHANNELS + 12);
    drain_requests();

    set_config(1, $urandom_range(0, 65535), 0, $urandom_range(0, 65535), 0);  // mid-frame drop
    run_phase(10);
    repeat (4) begin
      set_config($urandom_range(0, 40), $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 1));
      run_phase(10);
    end

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
